// ===== hw/rtl/hlg_pkg.sv =====
// shared constants and types for the hue-lightness grid color pick block
package hlg_pkg;

    localparam int FRAC_BITS_DEF = 24;

    localparam int POS_W   = 16;
    localparam int SIZE_W  = 12;
    localparam int CHAN_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GRID_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd3;

    localparam logic [SIZE_W-1:0] GRID_WIDTH_RST  = 12'd220;
    localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST = 12'd130;

    // ramp segment of one color channel
    typedef enum logic [1:0] {
        SEG_RISE = 2'd0,
        SEG_FLAT = 2'd1,
        SEG_FALL = 2'd2,
        SEG_LOW  = 2'd3
    } t_seg;

endpackage

// ===== hw/rtl/hlg_in_if.sv =====
// input channel: picked screen position
interface hlg_in_if
    import hlg_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

// ===== hw/rtl/hlg_out_if.sv =====
// output channel: picked color
interface hlg_out_if
    import hlg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              picked;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output picked, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input picked, input red, input green, input blue,
                    output ready);
endinterface

// ===== hw/rtl/hue_lightness_grid_color_pick_unit.sv =====
// top level: hue-lightness grid color pick pipeline
//
// usage
// - i_pos carries one picked screen position per beat (pos_x, pos_y)
// - o_color returns one beat per position: picked flag and 8-bit red, green, blue
// - the grid is set through a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
//   0 grid_left, 1 grid_top, 2 grid_width, 3 grid_height; write only while idle
// - picked is 0 and the color is black when grid_width is 0 or grid_height is below 2
// throughput and depth
// - one beat per cycle in and out while o_color.ready stays high
// - the depth is set by the two bit-serial dividers, one quotient bit per stage,
//   for the hue column and the lightness row
// reset
// - synchronous active-low i_rst_n empties the pipeline and restores the
//   default grid (origin 0,0, 220 by 130)
// stalls
// - each stage holds while the one ahead of it is full and stalled, so bubbles
//   close up; i_pos.ready drops only once every stage holds a beat
module hue_lightness_grid_color_pick_unit
    import hlg_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hlg_in_if.sink                i_pos,
    hlg_out_if.source             o_color
);

    // fixed point: W bits hold the value one
    localparam int W  = FRAC_BITS + 1;
    localparam int NS = FRAC_BITS + 4;          // pipeline stages
    localparam int SC = FRAC_BITS + 1;          // hsl setup stage
    localparam int SD = FRAC_BITS + 2;          // ramp multiply stage
    localparam int SO = FRAC_BITS + 3;          // output stage

    localparam logic [W-1:0] C_ONE        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [W-1:0] C_HALF       = C_ONE >> 1;
    localparam logic [W-1:0] C_THIRD      = C_ONE / 3;
    localparam logic [W-1:0] C_SIXTH      = C_ONE / 6;
    localparam logic [W:0]   C_TWO_THIRDS = ({1'b0, C_ONE} << 1) / 3;

    // configuration registers
    logic signed [POS_W-1:0] r_grid_left;
    logic signed [POS_W-1:0] r_grid_top;
    logic [SIZE_W-1:0]       r_grid_width;
    logic [SIZE_W-1:0]       r_grid_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_left   <= '0;
            r_grid_top    <= '0;
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRID_LEFT:   r_grid_left   <= i_cfg_data;
                REG_GRID_TOP:    r_grid_top    <= i_cfg_data;
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[SIZE_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // divisors must stay put while beats are in flight; the block does not enforce it
    logic [SIZE_W-1:0] w_hdiv;
    assign w_hdiv = r_grid_height - SIZE_W'(1);

    // valid bits and per-stage advance
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;
    logic [NS-1:0] r_use;           // grid usable, travels with the beat

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || o_color.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_pos.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_pos.valid;
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: clamp into the grid, start the dividers
    logic [SIZE_W-1:0] r_xrem [0:FRAC_BITS];
    logic [SIZE_W-1:0] r_yrem [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] r_xq [0:FRAC_BITS];
    logic [W-1:0]         r_yq [0:FRAC_BITS];

    logic signed [POS_W:0] w_dx, w_dy;
    logic signed [POS_W:0] w_xmax, w_ymax;
    logic [SIZE_W-1:0]     w_lx, w_ly;
    logic                  w_ytop;

    always_comb begin
        w_dx   = {i_pos.pos_x[POS_W-1], i_pos.pos_x} - {r_grid_left[POS_W-1], r_grid_left};
        w_dy   = {i_pos.pos_y[POS_W-1], i_pos.pos_y} - {r_grid_top[POS_W-1], r_grid_top};
        w_xmax = (POS_W+1)'(r_grid_width) - (POS_W+1)'(1);
        w_ymax = (POS_W+1)'(w_hdiv);
        if (w_dx < 0)           w_lx = '0;
        else if (w_dx > w_xmax) w_lx = w_xmax[SIZE_W-1:0];
        else                    w_lx = w_dx[SIZE_W-1:0];
        if (w_dy < 0)           w_ly = '0;
        else if (w_dy > w_ymax) w_ly = w_hdiv;
        else                    w_ly = w_dy[SIZE_W-1:0];
        // bottom row: integer bit of the row quotient is one
        w_ytop = (w_ly == w_hdiv);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_use[0]  <= (r_grid_width != '0) && (r_grid_height >= SIZE_W'(2));
            r_xrem[0] <= w_lx;
            r_xq[0]   <= '0;
            r_yrem[0] <= w_ytop ? '0 : w_ly;
            r_yq[0]   <= W'(w_ytop);
        end
    end

    // stages 1..FRAC_BITS: one quotient bit per stage for column and row
    for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_div
        logic [SIZE_W:0] w_xt, w_yt;
        logic            w_xge, w_yge;

        always_comb begin
            w_xt  = {r_xrem[j-1], 1'b0};
            w_yt  = {r_yrem[j-1], 1'b0};
            w_xge = w_xt >= {1'b0, r_grid_width};
            w_yge = w_yt >= {1'b0, w_hdiv};
        end

        always_ff @(posedge i_clk) begin
            if (w_en[j]) begin
                r_use[j]  <= r_use[j-1];
                r_xrem[j] <= w_xge ? SIZE_W'(w_xt - {1'b0, r_grid_width}) : w_xt[SIZE_W-1:0];
                r_yrem[j] <= w_yge ? SIZE_W'(w_yt - {1'b0, w_hdiv}) : w_yt[SIZE_W-1:0];
                r_xq[j]   <= {r_xq[j-1][FRAC_BITS-2:0], w_xge};
                r_yq[j]   <= {r_yq[j-1][W-2:0], w_yge};
            end
        end
    end

    // hsl setup: lightness to p and d, hue to a ramp segment per channel
    logic [W-1:0] w_l, w_l2, w_p, w_d;
    logic [W-1:0] w_hk;
    logic [W:0]   w_tr_sum;
    logic [W-1:0] w_t [3];
    t_seg         w_seg [3];
    logic [W-1:0] w_f [3];
    logic [W+2:0] w_six;
    logic [W-1:0] w_fall;

    always_comb begin
        w_l  = C_ONE - r_yq[FRAC_BITS];
        w_l2 = W'({w_l, 1'b0});
        if (w_l < C_HALF) begin
            w_p = '0;
            w_d = w_l2;
        end else begin
            w_p = w_l2 - C_ONE;
            w_d = C_ONE - w_p;
        end
        w_hk     = {1'b0, r_xq[FRAC_BITS]};
        w_tr_sum = {1'b0, w_hk} + {1'b0, C_THIRD};
        w_t[0]   = (w_tr_sum > {1'b0, C_ONE}) ? W'(w_tr_sum - {1'b0, C_ONE})
                                               : w_tr_sum[W-1:0];
        w_t[1]   = w_hk;
        w_t[2]   = (w_hk < C_THIRD) ? (w_hk + C_ONE - C_THIRD) : (w_hk - C_THIRD);
        w_six    = '0;
        w_fall   = '0;
        for (int c = 0; c < 3; c++) begin
            w_fall = C_TWO_THIRDS[W-1:0] - w_t[c];
            if (w_t[c] < C_SIXTH) begin
                w_seg[c] = SEG_RISE;
                w_six    = ((W+3)'(w_t[c]) << 2) + ((W+3)'(w_t[c]) << 1);
            end else if (w_t[c] < C_HALF) begin
                w_seg[c] = SEG_FLAT;
                w_six    = '0;
            end else if ({1'b0, w_t[c]} < C_TWO_THIRDS) begin
                w_seg[c] = SEG_FALL;
                w_six    = ((W+3)'(w_fall) << 2) + ((W+3)'(w_fall) << 1);
            end else begin
                w_seg[c] = SEG_LOW;
                w_six    = '0;
            end
            w_f[c] = w_six[W-1:0];
        end
    end

    logic [W-1:0] r_p, r_d;
    t_seg         r_seg [3];
    logic [W-1:0] r_f [3];

    always_ff @(posedge i_clk) begin
        if (w_en[SC]) begin
            r_use[SC] <= r_use[SC-1];
            r_p       <= w_p;
            r_d       <= w_d;
            for (int c = 0; c < 3; c++) begin
                r_seg[c] <= w_seg[c];
                r_f[c]   <= w_f[c];
            end
        end
    end

    // ramp multiply and channel value
    logic [2*W-1:0] w_prod [3];
    logic [W-1:0]   w_v [3];
    logic [W-1:0]   r_v_ch [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_prod[c] = r_d * r_f[c];
            case (r_seg[c])
                SEG_RISE, SEG_FALL: w_v[c] = r_p + w_prod[c][FRAC_BITS +: W];
                SEG_FLAT:           w_v[c] = r_p + r_d;
                default:            w_v[c] = r_p;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[SD]) begin
            r_use[SD] <= r_use[SD-1];
            for (int c = 0; c < 3; c++) r_v_ch[c] <= w_v[c];
        end
    end

    // scale to 8 bits: v*255 rounded, saturated
    logic [W+7:0]        w_sc [3];
    logic [CHAN_W:0]     w_cw [3];
    logic [CHAN_W-1:0]   w_ch [3];
    logic [CHAN_W-1:0]   r_ch [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sc[c] = ((W+8)'(r_v_ch[c]) << 8) - (W+8)'(r_v_ch[c]) + (W+8)'(C_HALF);
            w_cw[c] = w_sc[c][FRAC_BITS +: CHAN_W+1];
            w_ch[c] = w_cw[c][CHAN_W] ? {CHAN_W{1'b1}} : w_cw[c][CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[SO]) begin
            r_use[SO] <= r_use[SO-1];
            for (int c = 0; c < 3; c++) r_ch[c] <= r_use[SO-1] ? w_ch[c] : '0;
        end
    end

    assign o_color.valid  = r_v[SO];
    assign o_color.picked = r_use[SO];
    assign o_color.red    = r_ch[0];
    assign o_color.green  = r_ch[1];
    assign o_color.blue   = r_ch[2];

endmodule

// ===== hw/rtl/hlg_chk.sv =====
// port-level checker for the color pick block, bound to the top level
module hlg_chk
    import hlg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_picked,
    input logic [CHAN_W-1:0] i_red,
    input logic [CHAN_W-1:0] i_green,
    input logic [CHAN_W-1:0] i_blue
);

    // result beat waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat after reset");

    // an empty output stage never blocks the input
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with free output");

    // unusable grid gives black
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_picked |-> (i_red == '0) && (i_green == '0) && (i_blue == '0))
        else $error("color on unusable grid");

endmodule

bind hue_lightness_grid_color_pick_unit hlg_chk u_hlg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pos.ready),
    .i_out_valid (o_color.valid),
    .i_out_ready (o_color.ready),
    .i_picked    (o_color.picked),
    .i_red       (o_color.red),
    .i_green     (o_color.green),
    .i_blue      (o_color.blue)
);

// ===== tb/tb_hue_lightness_grid_color_pick_unit.sv =====
// testbench for the hue-lightness grid color pick unit: directed and random positions
`timescale 1ns / 100ps

module tb_hue_lightness_grid_color_pick_unit;
    import hlg_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = FB + 4;

    // expected color of one position
    typedef struct packed {
        logic              picked;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_color;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hlg_in_if  pos_if ();
    hlg_out_if color_if ();

    hue_lightness_grid_color_pick_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pos      (pos_if.sink),
        .o_color    (color_if.source)
    );

    // grid registers as the predictor sees them
    logic signed [POS_W-1:0] grid_left_q;
    logic signed [POS_W-1:0] grid_top_q;
    logic [SIZE_W-1:0] grid_width_q;
    logic [SIZE_W-1:0] grid_height_q;

    t_color pending_colors[$];
    int fail_count;
    bit idle_enable;   // off gives a stretch with no idling on either side

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("** hue_lightness_grid_color_pick_unit: FAILED **");
        $finish;
    end

    // one channel of the piecewise hsl rule, rounded to 8 bits
    function automatic logic [CHAN_W-1:0] ramp_channel(longint t, longint unsigned p,
                                                       longint unsigned d);
        longint unsigned one, v, c;
        one = 64'd1 << FB;
        if (t < 0) t += one;
        if (t > one) t -= one;
        if (t < one / 6)
            v = p + ((d * (6 * t)) >> FB);
        else if (t < one / 2)
            v = p + d;
        else if (t < (one * 2) / 3)
            v = p + ((d * (6 * ((one * 2) / 3 - t))) >> FB);
        else
            v = p;
        c = (v * 255 + one / 2) >> FB;
        return (c > 255) ? 8'd255 : c[CHAN_W-1:0];
    endfunction

    function automatic t_color pick_color(logic signed [POS_W-1:0] px,
                                          logic signed [POS_W-1:0] py);
        t_color col;
        longint lx, ly, hk;
        longint unsigned one, lit, q, p;
        one = 64'd1 << FB;
        col = '0;
        if (grid_width_q == 0 || grid_height_q < 2) return col;
        lx = longint'(px) - longint'(grid_left_q);
        ly = longint'(py) - longint'(grid_top_q);
        if (lx < 0) lx = 0;
        if (lx > grid_width_q - 1) lx = grid_width_q - 1;
        if (ly < 0) ly = 0;
        if (ly > grid_height_q - 1) ly = grid_height_q - 1;
        hk = (lx << FB) / grid_width_q;
        lit = one - ((ly << FB) / (grid_height_q - 1));
        if (lit < one / 2) begin
            q = 2 * lit;
            p = 0;
        end else begin
            q = one;
            p = 2 * lit - one;
        end
        col.picked = 1'b1;
        col.red   = ramp_channel(hk + one / 3, p, q - p);
        col.green = ramp_channel(hk, p, q - p);
        col.blue  = ramp_channel(hk - one / 3, p, q - p);
        return col;
    endfunction

    // register write, only while the pipeline is empty
    task automatic write_grid_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_GRID_LEFT:   grid_left_q   = val;
            REG_GRID_TOP:    grid_top_q    = val;
            REG_GRID_WIDTH:  grid_width_q  = val[SIZE_W-1:0];
            REG_GRID_HEIGHT: grid_height_q = val[SIZE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_grid(int left, int top, int w, int h);
        write_grid_reg(REG_GRID_LEFT, left[15:0]);
        write_grid_reg(REG_GRID_TOP, top[15:0]);
        write_grid_reg(REG_GRID_WIDTH, w[15:0]);
        write_grid_reg(REG_GRID_HEIGHT, h[15:0]);
    endtask

    // send one position beat; called at a falling edge
    task automatic send_pos(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py);
        while (idle_enable && $urandom_range(99) < 8) @(negedge i_clk);
        pos_if.valid = 1'b1;
        pos_if.pos_x = px;
        pos_if.pos_y = py;
        do @(posedge i_clk); while (!pos_if.ready);
        pending_colors.push_back(pick_color(px, py));
        @(negedge i_clk);
        pos_if.valid = 1'b0;
    endtask

    // wait until every expected color is back, then let the pipe drain
    task automatic drain_pipe();
        wait (pending_colors.size() == 0);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_color exp_c;
        if (i_rst_n && color_if.valid && color_if.ready) begin
            if (pending_colors.size() == 0) begin
                $error("color beat with nothing expected");
                fail_count++;
            end else begin
                exp_c = pending_colors.pop_front();
                if (color_if.picked !== exp_c.picked) begin
                    $error("picked exp %0d got %0d", exp_c.picked, color_if.picked);
                    fail_count++;
                end
                if (color_if.red !== exp_c.red) begin
                    $error("red exp %0d got %0d", exp_c.red, color_if.red);
                    fail_count++;
                end
                if (color_if.green !== exp_c.green) begin
                    $error("green exp %0d got %0d", exp_c.green, color_if.green);
                    fail_count++;
                end
                if (color_if.blue !== exp_c.blue) begin
                    $error("blue exp %0d got %0d", exp_c.blue, color_if.blue);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk)
        color_if.ready <= !(idle_enable && $urandom_range(99) < 8);

    // default grid straight out of reset, corners and far outside points
    task automatic test_reset_grid();
        send_pos(16'sd0, 16'sd0);
        send_pos(16'sd219, 16'sd129);
        send_pos(-16'sd32768, -16'sd32768);
        send_pos(16'sd32767, 16'sd32767);
        send_pos(16'sd110, 16'sd65);
        send_pos(16'sd73, 16'sd32767);
    endtask

    // hue sweep across every sixth, full lightness range
    task automatic test_hue_sweep();
        drain_pipe();
        set_grid(-100, 50, 6, 3);
        for (int i = -101; i <= -94; i++) send_pos(16'(i), 16'sd51);
        send_pos(-16'sd97, 16'sd50);
        send_pos(-16'sd97, 16'sd52);
    endtask

    // unusable grid sizes give black with picked low
    task automatic test_unusable_grid();
        drain_pipe();
        set_grid(0, 0, 0, 100);
        send_pos(16'sd5, 16'sd5);
        drain_pipe();
        write_grid_reg(REG_GRID_WIDTH, 16'd10);
        write_grid_reg(REG_GRID_HEIGHT, 16'd1);
        send_pos(16'sd5, 16'sd0);
        drain_pipe();
        write_grid_reg(REG_GRID_HEIGHT, 16'd0);
        send_pos(-16'sd5, 16'sd3);
    endtask

    // largest, smallest and random grids with random origins, extremes of the size registers
    task automatic test_random_grids(int n_sets, int per_set);
        int w, h, l, t;
        for (int s = 0; s < n_sets; s++) begin
            drain_pipe();
            case (s % 4)
                0: begin w = 4095; h = 4095; end
                1: begin w = 1; h = 2; end
                2: begin w = $urandom_range(1, 4095); h = $urandom_range(2, 4095); end
                default: begin w = $urandom_range(1, 400); h = $urandom_range(2, 300); end
            endcase
            if (s % 23 == 7) h = $urandom_range(0, 1);
            if (s % 29 == 11) w = 0;
            l = $urandom_range(0, 65535);
            t = $urandom_range(0, 65535);
            if (s == 2) begin l = 32767; t = -32768; end
            if (s == 6) begin l = -32768; t = 32767; end
            set_grid(l, t, w, h);
            for (int k = 0; k < per_set; k++) begin
                if ($urandom_range(9) < 8)
                    send_pos(16'(l + $urandom_range(0, w)), 16'(t + $urandom_range(0, h)));
                else
                    send_pos(16'($urandom), 16'($urandom));
            end
            // sender holds off until every color is back
            if (s == 5) wait (pending_colors.size() == 0);
        end
    endtask

    initial begin
        fail_count = 0;
        idle_enable = 1'b1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        pos_if.valid = 1'b0;
        pos_if.pos_x = '0;
        pos_if.pos_y = '0;
        color_if.ready = 1'b1;
        grid_left_q = '0;
        grid_top_q = '0;
        grid_width_q = GRID_WIDTH_RST;
        grid_height_q = GRID_HEIGHT_RST;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_grid();
        test_hue_sweep();
        test_unusable_grid();
        test_random_grids(40, 20);
        idle_enable = 1'b0;
        test_random_grids(10, 40);
        idle_enable = 1'b1;
        test_random_grids(20, 20);

        drain_pipe();
        if (fail_count == 0)
            $display("** hue_lightness_grid_color_pick_unit: PASSED **");
        else
            $display("** hue_lightness_grid_color_pick_unit: FAILED **");
        $finish;
    end

endmodule
